// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the queue RTL
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bpq_pkg.sv -----
// ---------------------------------------------------------------------------
// bpq_pkg
// Types, codes and the urgency compare of the bounded priority queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpq_pkg;

    localparam int FUEL_W   = 8;
    localparam int LOAD_W   = 10;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 4;

    // Operation codes on the input tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [LOAD_W-1:0] load;
        logic [FUEL_W-1:0] fuel;
    } entry_t;

    // What every cell does in the current cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    // Broadcast from the controller to all cells
    typedef struct packed {
        cell_op_t op;
        logic     full;
        entry_t   item;
        entry_t   last;
    } cell_ctrl_t;

    // True when a is strictly more urgent than b
    function automatic logic more_urgent(entry_t a, entry_t b);
        return (a.fuel < b.fuel) || ((a.fuel == b.fuel) && (a.load > b.load));
    endfunction

endpackage

// ----- hw/rtl/bpq_cell.sv -----
// ---------------------------------------------------------------------------
// bpq_cell
// One slot of the sorted queue: holds an entry, takes it from a neighbor
// or from the broadcast item as the controller directs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpq_cell (
    input  logic                clk,
    input  bpq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  bpq_pkg::entry_t     left_entry,
    input  logic                left_go,
    input  logic                left_tail,
    input  bpq_pkg::entry_t     right_entry,
    output bpq_pkg::entry_t     entry,
    output logic                go,
    output logic                tail
);

    bpq_pkg::entry_t entry_reg;
    bpq_pkg::entry_t entry_next;

    // Flag slots the new item goes in front of, and the run of least urgent keys
    assign go   = !occupied || bpq_pkg::more_urgent(ctrl.item, entry_reg);
    assign tail = occupied && (entry_reg.fuel == ctrl.last.fuel)
                           && (entry_reg.load == ctrl.last.load);

    // Choose the next content of the slot
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            bpq_pkg::CELL_INSERT:
            begin
                if (go && !(ctrl.full && left_tail))
                begin
                    entry_next = left_go ? left_entry : ctrl.item;
                end
            end
            bpq_pkg::CELL_REMOVE:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- hw/rtl/bounded_priority_queue_replace_worst.sv -----
// ---------------------------------------------------------------------------
// bounded_priority_queue_replace_worst
// Sorted priority queue of DEPTH slots built as a row of cells; a full queue
// replaces its least urgent entry when a more urgent item arrives.
// ---------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)                          tuser
//  s_axis    in         fuel_key, load_key, item_tag, pad to 32     operation
//  m_axis    out        head_fuel, head_load, head_tag, occupancy,  status
//                       pad to 32
//
//  One transaction is taken per cycle unless m_axis stalls: every cell
//  compares against the broadcast item and shifts in the same cycle, so
//  an insert or remove finishes at the edge that accepts it.
//  The result sits in one output register; s_axis_tready is high while that
//  register is empty or being drained, so a stall on m_axis holds the input.
//  Reset clears the held count and the output valid; slot contents need none.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounded_priority_queue_replace_worst #(
    parameter int DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // fuel_key[7:0], load_key[17:8], item_tag[25:18]
    input  logic        s_axis_tuser,   // operation[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // head_fuel[7:0], head_load[17:8],
                                        // head_tag[25:18], occupancy[29:26]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = (CW > bpq_pkg::OCC_W) ? CW : bpq_pkg::OCC_W;

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      m_valid_reg;
    logic [bpq_pkg::STATUS_W-1:0] status_reg;
    logic [bpq_pkg::STATUS_W-1:0] status_next;
    bpq_pkg::entry_t           head_reg;
    bpq_pkg::entry_t           head_next;
    logic [bpq_pkg::OCC_W-1:0] occ_reg;
    logic [OW-1:0]             count_ext;

    logic                      s_fire;
    logic                      op;
    logic                      full;
    bpq_pkg::entry_t           item;
    bpq_pkg::cell_ctrl_t       ctrl;

    bpq_pkg::entry_t           entry_w [DEPTH];
    logic                      go_w    [DEPTH];
    logic                      tail_w  [DEPTH];

    // Unpack the input transaction
    assign op        = s_axis_tuser;
    assign item.fuel = s_axis_tdata[7:0];
    assign item.load = s_axis_tdata[17:8];
    assign item.tag  = s_axis_tdata[25:18];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == CW'(DEPTH));

    // Decide the cell operation, status and new count
    always_comb
    begin
        ctrl.op     = bpq_pkg::CELL_HOLD;
        ctrl.full   = full;
        ctrl.item   = item;
        ctrl.last   = entry_w[DEPTH-1];
        count_next  = count_reg;
        status_next = bpq_pkg::ST_REJECTED;
        head_next   = '0;
        if (op == bpq_pkg::OP_REMOVE)
        begin
            if (count_reg == '0)
            begin
                status_next = bpq_pkg::ST_EMPTY;
            end
            else
            begin
                ctrl.op     = bpq_pkg::CELL_REMOVE;
                status_next = bpq_pkg::ST_REMOVED;
                head_next   = entry_w[0];
                count_next  = count_reg - CW'(1);
            end
        end
        else if (!full)
        begin
            ctrl.op     = bpq_pkg::CELL_INSERT;
            status_next = bpq_pkg::ST_INSERTED;
            count_next  = count_reg + CW'(1);
        end
        else if (bpq_pkg::more_urgent(item, entry_w[DEPTH-1]))
        begin
            ctrl.op     = bpq_pkg::CELL_INSERT;
            status_next = bpq_pkg::ST_EVICTED;
        end
        if (!s_fire)
        begin
            ctrl.op    = bpq_pkg::CELL_HOLD;
            count_next = count_reg;
        end
    end

    // Row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        bpq_pkg::entry_t left_entry;
        bpq_pkg::entry_t right_entry;
        logic            left_go;
        logic            left_tail;

        if (i == 0)
        begin : g_first
            assign left_entry = item;
            assign left_go    = 1'b0;
            assign left_tail  = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry = entry_w[i-1];
            assign left_go    = go_w[i-1];
            assign left_tail  = tail_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = entry_w[i];
        end
        else
        begin : g_mid
            assign right_entry = entry_w[i+1];
        end

        bpq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (CW'(i) < count_reg),
            .left_entry  (left_entry),
            .left_go     (left_go),
            .left_tail   (left_tail),
            .right_entry (right_entry),
            .entry       (entry_w[i]),
            .go          (go_w[i]),
            .tail        (tail_w[i])
        );
    end

    // Hold count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (s_fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign count_ext = OW'(count_next);

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            status_reg <= status_next;
            head_reg   <= head_next;
            occ_reg    <= count_ext[bpq_pkg::OCC_W-1:0];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {2'b00, occ_reg, head_reg.tag, head_reg.load, head_reg.fuel};

    `ASSERT_CLK(a_count_bound, count_reg <= CW'(DEPTH), "held count above depth")
    `ASSERT_IMPL(a_ready_when_free, !m_valid_reg, s_axis_tready, "input stalled with empty output")
    `ASSERT_NEXT(a_remove_count, s_fire && (op == bpq_pkg::OP_REMOVE) && (count_reg != '0),
        count_reg == $past(count_reg) - CW'(1), "remove did not drop one entry")
    `ASSERT_NEXT(a_evict_full, s_fire && full && (op == bpq_pkg::OP_INSERT),
        count_reg == CW'(DEPTH), "insert into full queue changed count")
    `ASSERT_IMPL(a_empty_zero, m_valid_reg && (status_reg == bpq_pkg::ST_EMPTY),
        (occ_reg == '0) && (head_reg == '0), "empty result carries data")

endmodule
